### hdl/gccb_pkg.sv
// Package for the glyph coverage clip and blend unit.
// Holds register indexes, widths and the configuration struct; no dependencies.
package gccb_pkg;

    localparam int ADDR_BITS_DEF = 26;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FG_ARGB      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 4'd7;

    localparam logic [31:0] FG_ARGB_RST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0]        fg_argb;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_width;
        logic signed [15:0] clip_height;
        logic [12:0]        frame_width;
        logic [12:0]        frame_height;
        logic [13:0]        row_stride;
    } t_cfg;

endpackage

### hdl/gccb_cfg_regs.sv
// Configuration register file of the glyph coverage clip and blend unit.
// Depends on gccb_pkg for register indexes and the t_cfg struct.
module gccb_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gccb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gccb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output gccb_pkg::t_cfg                     o_cfg
);

    gccb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_argb      <= gccb_pkg::FG_ARGB_RST;
            r_cfg.clip_left    <= '0;
            r_cfg.clip_top     <= '0;
            r_cfg.clip_width   <= '0;
            r_cfg.clip_height  <= '0;
            r_cfg.frame_width  <= '0;
            r_cfg.frame_height <= '0;
            r_cfg.row_stride   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gccb_pkg::REG_FG_ARGB: begin
                    r_cfg.fg_argb <= i_cfg_data;
                end
                gccb_pkg::REG_CLIP_LEFT: begin
                    r_cfg.clip_left <= i_cfg_data[15:0];
                end
                gccb_pkg::REG_CLIP_TOP: begin
                    r_cfg.clip_top <= i_cfg_data[15:0];
                end
                gccb_pkg::REG_CLIP_WIDTH: begin
                    r_cfg.clip_width <= i_cfg_data[15:0];
                end
                gccb_pkg::REG_CLIP_HEIGHT: begin
                    r_cfg.clip_height <= i_cfg_data[15:0];
                end
                gccb_pkg::REG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= i_cfg_data[12:0];
                end
                gccb_pkg::REG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data[12:0];
                end
                gccb_pkg::REG_ROW_STRIDE: begin
                    r_cfg.row_stride <= i_cfg_data[13:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/glyph_coverage_clip_blend_unit.sv
// Top level of the glyph coverage clip and blend unit: four-stage pipeline.
// Depends on gccb_pkg and gccb_cfg_regs.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one glyph pixel request
//   (position, coverage, current framebuffer pixel). Output channel:
//   o_out_valid / i_out_stall carry write flag, address and new pixel.
//   A request is taken at a clock edge with valid high and stall low.
//   The request passes four register stages before o_out_valid rises; one
//   request per cycle is sustained while i_out_stall is low. The stages are:
//   clip test and coverage/stride multiplies, divide-by-255 and address add,
//   channel multiplies, result select into the output register.
//   When i_out_stall is high a full output register holds; earlier stages keep
//   filling empty slots and o_in_stall rises only once every stage is full.
//   Synchronous active-low reset empties the pipeline and loads the
//   configuration reset values (text color all ones, everything else zero).
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no request is in flight.
module glyph_coverage_clip_blend_unit #(
    parameter int ADDR_BITS = gccb_pkg::ADDR_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gccb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gccb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [15:0]                 i_pixel_x,
    input  logic signed [15:0]                 i_pixel_y,
    input  logic [7:0]                         i_coverage,
    input  logic [31:0]                        i_dest_pixel,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_write_enable,
    output logic [ADDR_BITS-1:0]               o_write_address,
    output logic [31:0]                        o_new_pixel
);

    function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] sa, input logic [7:0] inv);
        logic [15:0] sum;
        sum = ({8'd0, s} * {8'd0, sa}) + ({8'd0, d} * {8'd0, inv});
        return sum[15:8];
    endfunction

    gccb_pkg::t_cfg w_cfg;

    gccb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // flow control
    logic w_adv1, w_adv2, w_adv3, w_adv_out;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;

    assign w_adv_out  = !r_out_vld || !i_out_stall;
    assign w_adv3     = !r_s3_vld || w_adv_out;
    assign w_adv2     = !r_s2_vld || w_adv3;
    assign w_adv1     = !r_s1_vld || w_adv2;
    assign o_in_stall = !w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_s1_vld <= i_in_valid;
            end
            if (w_adv2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_adv3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (w_adv_out) begin
                r_out_vld <= r_s3_vld;
            end
        end
    end

    // stage 1: clip test, coverage * alpha, row * stride
    logic signed [16:0] w_x0, w_y0, w_x1_raw, w_y1_raw, w_x1, w_y1, w_px, w_py;
    logic               w_inside;
    logic [7:0]         w_ca;
    logic [15:0]        n_s1_prod;
    logic signed [31:0] n_s1_aprod;

    assign w_x0     = {w_cfg.clip_left[15], w_cfg.clip_left};
    assign w_y0     = {w_cfg.clip_top[15], w_cfg.clip_top};
    assign w_x1_raw = w_x0 + {w_cfg.clip_width[15], w_cfg.clip_width};
    assign w_y1_raw = w_y0 + {w_cfg.clip_height[15], w_cfg.clip_height};
    assign w_x1     = (w_x1_raw <= 17'sd0) ? $signed({4'd0, w_cfg.frame_width}) : w_x1_raw;
    assign w_y1     = (w_y1_raw <= 17'sd0) ? $signed({4'd0, w_cfg.frame_height}) : w_y1_raw;
    assign w_px     = {i_pixel_x[15], i_pixel_x};
    assign w_py     = {i_pixel_y[15], i_pixel_y};
    assign w_inside = (w_px >= w_x0) && (w_px < w_x1) && (w_py >= w_y0) && (w_py < w_y1);
    assign w_ca     = w_cfg.fg_argb[31:24];
    assign n_s1_prod  = {8'd0, i_coverage} * {8'd0, w_ca};
    assign n_s1_aprod = i_pixel_y * $signed({1'b0, w_cfg.row_stride});

    logic               r_s1_wr, r_s1_opq;
    logic [15:0]        r_s1_prod;
    logic signed [31:0] r_s1_aprod;
    logic signed [15:0] r_s1_px;
    logic [31:0]        r_s1_dst;

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_in_valid) begin
            r_s1_wr    <= w_inside && (i_coverage != 8'd0);
            r_s1_opq   <= (i_coverage == 8'hFF) && (w_ca == 8'hFF);
            r_s1_prod  <= n_s1_prod;
            r_s1_aprod <= n_s1_aprod;
            r_s1_px    <= i_pixel_x;
            r_s1_dst   <= i_dest_pixel;
        end
    end

    // stage 2: exact divide by 255 for a product of two 8-bit values, address add
    logic [15:0] w_sa_sum;
    logic [31:0] w_addr_full;

    assign w_sa_sum    = r_s1_prod + {8'd0, r_s1_prod[15:8]} + 16'd1;
    assign w_addr_full = r_s1_aprod + {{16{r_s1_px[15]}}, r_s1_px};

    logic                 r_s2_wr, r_s2_opq;
    logic [7:0]           r_s2_sa;
    logic [ADDR_BITS-1:0] r_s2_addr;
    logic [31:0]          r_s2_dst;

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_s1_vld) begin
            r_s2_wr   <= r_s1_wr;
            r_s2_opq  <= r_s1_opq;
            r_s2_sa   <= w_sa_sum[15:8];
            r_s2_addr <= w_addr_full[ADDR_BITS-1:0];
            r_s2_dst  <= r_s1_dst;
        end
    end

    // stage 3: per-channel blend
    logic [7:0]  w_inv;
    logic [15:0] w_da_inv;

    assign w_inv    = 8'd255 - r_s2_sa;
    assign w_da_inv = {8'd0, r_s2_dst[31:24]} * {8'd0, w_inv};

    logic                 r_s3_wr, r_s3_opq;
    logic [31:0]          r_s3_blend;
    logic [ADDR_BITS-1:0] r_s3_addr;
    logic [31:0]          r_s3_dst;

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_s2_vld) begin
            r_s3_wr    <= r_s2_wr;
            r_s3_opq   <= r_s2_opq;
            r_s3_blend <= {r_s2_sa + w_da_inv[15:8],
                           mix(w_cfg.fg_argb[23:16], r_s2_dst[23:16], r_s2_sa, w_inv),
                           mix(w_cfg.fg_argb[15:8],  r_s2_dst[15:8],  r_s2_sa, w_inv),
                           mix(w_cfg.fg_argb[7:0],   r_s2_dst[7:0],   r_s2_sa, w_inv)};
            r_s3_addr  <= r_s2_addr;
            r_s3_dst   <= r_s2_dst;
        end
    end

    // output register: select opaque, blended or untouched pixel
    logic                 r_out_we;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [31:0]          r_out_pix;
    logic [31:0]          n_out_pix;

    always_comb begin
        if (!r_s3_wr) begin
            n_out_pix = r_s3_dst;
        end else if (r_s3_opq) begin
            n_out_pix = {8'hFF, w_cfg.fg_argb[23:0]};
        end else begin
            n_out_pix = r_s3_blend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out && r_s3_vld) begin
            r_out_we   <= r_s3_wr;
            r_out_addr <= r_s3_wr ? r_s3_addr : '0;
            r_out_pix  <= n_out_pix;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_write_enable  = r_out_we;
    assign o_write_address = r_out_addr;
    assign o_new_pixel     = r_out_pix;

`ifndef NO_ASSERTIONS
    a_no_write_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_enable) |-> (o_write_address == '0))
        else $error("address nonzero on a request without write");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s2_vld && r_s3_vld && r_out_vld && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipeline full and output stalled");

    a_free_slot_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_vld || !r_s2_vld || !r_s3_vld || !r_out_vld || !i_out_stall) |-> !o_in_stall)
        else $error("input stalled with a free pipeline slot");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

### tb/sv/tb_glyph_coverage_clip_blend_unit.sv
// Self-checking testbench for glyph_coverage_clip_blend_unit: clip test, address and blend.
// Needs gccb_pkg and the unit's RTL; predicts every request and checks its result on the output.
module tb_glyph_coverage_clip_blend_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W      = gccb_pkg::ADDR_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 13;
    localparam logic [gccb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
    localparam logic [gccb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         cov;
        logic [31:0]        dest;
    } t_glyph_px;

    typedef struct {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       pix;
    } t_fb_write;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [gccb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gccb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic signed [15:0]              pix_x = '0;
    logic signed [15:0]              pix_y = '0;
    logic [7:0]                      coverage = '0;
    logic [31:0]                     dest_pixel = '0;
    logic                            out_stall = 1'b0;
    logic                            in_stall;
    logic                            out_valid;
    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [31:0]                     new_pixel;

    gccb_pkg::t_cfg fb_cfg;
    t_glyph_px      glyph_queue[$];
    t_fb_write      predicted_writes[$];

    logic      steady = 1'b0;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    int        cycles = 0;
    int        mismatches = 0;
    int        accepted = 0;
    int        writes_seen = 0;
    int        opaque_seen = 0;
    int        max_in_stall_run = 0;
    int        in_stall_run = 0;

    glyph_coverage_clip_blend_unit #(.ADDR_BITS(ADDR_W)) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_pixel_x       (pix_x),
        .i_pixel_y       (pix_y),
        .i_coverage      (coverage),
        .i_dest_pixel    (dest_pixel),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_write_enable  (wr_en),
        .o_write_address (wr_addr),
        .o_new_pixel     (new_pixel)
    );

    always #10 clk = ~clk;

    // Right/bottom edges are taken at full width; at or below zero the frame size stands in.
    function automatic void clip_bounds(input gccb_pkg::t_cfg c, output int x0, output int y0,
                                        output int x1, output int y1);
        x0 = $signed(c.clip_left);
        y0 = $signed(c.clip_top);
        x1 = x0 + int'($signed(c.clip_width));
        y1 = y0 + int'($signed(c.clip_height));
        if (x1 <= 0) begin
            x1 = int'(c.frame_width);
        end
        if (y1 <= 0) begin
            y1 = int'(c.frame_height);
        end
    endfunction

    function automatic t_fb_write predict_write(input t_glyph_px p, input gccb_pkg::t_cfg c);
        int          x0, y0, x1, y1, px, py;
        longint      lin;
        int unsigned cov, ca, sa, inv, oa, r, g, b;
        t_fb_write   w;
        clip_bounds(c, x0, y0, x1, y1);
        px = p.x;
        py = p.y;
        w.we = 1'b0;
        w.addr = '0;
        w.pix = p.dest;
        if (p.cov == 8'd0 || px < x0 || px >= x1 || py < y0 || py >= y1) begin
            return w;
        end
        lin = longint'(py) * longint'(c.row_stride) + longint'(px);
        w.we = 1'b1;
        w.addr = lin[ADDR_W-1:0];
        cov = p.cov;
        ca = c.fg_argb[31:24];
        if (cov == 255 && ca == 255) begin
            w.pix = {8'hFF, c.fg_argb[23:0]};
        end else begin
            sa = (cov * ca) / 255;
            inv = 255 - sa;
            oa = sa + ((p.dest[31:24] * inv) >> 8);
            r = (c.fg_argb[23:16] * sa + p.dest[23:16] * inv) >> 8;
            g = (c.fg_argb[15:8] * sa + p.dest[15:8] * inv) >> 8;
            b = (c.fg_argb[7:0] * sa + p.dest[7:0] * inv) >> 8;
            w.pix = {oa[7:0], r[7:0], g[7:0], b[7:0]};
        end
        return w;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Sender: offers queued requests, idles at random unless steady.
    always @(posedge clk) begin
        t_glyph_px nxt;
        t_glyph_px cur;
        t_fb_write w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                cur.x = pix_x;
                cur.y = pix_y;
                cur.cov = coverage;
                cur.dest = dest_pixel;
                w = predict_write(cur, fb_cfg);
                predicted_writes.push_back(w);
                accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (glyph_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = glyph_queue.pop_front();
                    pix_x <= nxt.x;
                    pix_y <= nxt.y;
                    coverage <= nxt.cov;
                    dest_pixel <= nxt.dest;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (in_valid && in_stall) begin
                in_stall_run++;
                if (in_stall_run > max_in_stall_run) begin
                    max_in_stall_run = in_stall_run;
                end
            end else begin
                in_stall_run = 0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_served <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        t_fb_write want;
        if (rst_n && out_valid && !out_stall) begin
            if (predicted_writes.size() == 0) begin
                report($sformatf("unexpected result we=%0b addr=%h pix=%h",
                                 wr_en, wr_addr, new_pixel));
            end else begin
                want = predicted_writes.pop_front();
                if (wr_en !== want.we || wr_addr !== want.addr || new_pixel !== want.pix) begin
                    report($sformatf({"mismatch exp we=%0b addr=%h pix=%h",
                                      " got we=%0b addr=%h pix=%h"},
                                     want.we, want.addr, want.pix, wr_en, wr_addr, new_pixel));
                end
                if (want.we) begin
                    writes_seen++;
                    if (want.pix[31:24] == 8'hFF && fb_cfg.fg_argb[31:24] == 8'hFF) begin
                        opaque_seen++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, predicted_writes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [gccb_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            gccb_pkg::REG_FG_ARGB:      fb_cfg.fg_argb = val;
            gccb_pkg::REG_CLIP_LEFT:    fb_cfg.clip_left = val[15:0];
            gccb_pkg::REG_CLIP_TOP:     fb_cfg.clip_top = val[15:0];
            gccb_pkg::REG_CLIP_WIDTH:   fb_cfg.clip_width = val[15:0];
            gccb_pkg::REG_CLIP_HEIGHT:  fb_cfg.clip_height = val[15:0];
            gccb_pkg::REG_FRAME_WIDTH:  fb_cfg.frame_width = val[12:0];
            gccb_pkg::REG_FRAME_HEIGHT: fb_cfg.frame_height = val[12:0];
            gccb_pkg::REG_ROW_STRIDE:   fb_cfg.row_stride = val[13:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_clip(input logic [31:0] color, input logic [31:0] left,
                            input logic [31:0] top, input logic [31:0] w,
                            input logic [31:0] h, input logic [31:0] fw,
                            input logic [31:0] fh, input logic [31:0] stride);
        write_reg(gccb_pkg::REG_FG_ARGB, color);
        write_reg(gccb_pkg::REG_CLIP_LEFT, left);
        write_reg(gccb_pkg::REG_CLIP_TOP, top);
        write_reg(gccb_pkg::REG_CLIP_WIDTH, w);
        write_reg(gccb_pkg::REG_CLIP_HEIGHT, h);
        write_reg(gccb_pkg::REG_FRAME_WIDTH, fw);
        write_reg(gccb_pkg::REG_FRAME_HEIGHT, fh);
        write_reg(gccb_pkg::REG_ROW_STRIDE, stride);
    endtask

    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (glyph_queue.size() != 0 || in_valid || predicted_writes.size() != 0);
    endtask

    function automatic void queue_pixel(input int x, input int y, input int cov,
                                        input logic [31:0] dest);
        glyph_queue.push_back('{16'(x), 16'(y), 8'(cov), dest});
    endfunction

    // Mostly edges and points inside the window, some anywhere.
    function automatic int pick_coord(input int lo, input int hi);
        case ($urandom_range(9))
            0: return lo - 1;
            1: return lo;
            2: return hi - 1;
            3: return hi;
            4: return int'($urandom());
            default: begin
                if (hi > lo) begin
                    return lo + int'($urandom_range(hi - lo - 1));
                end
                return int'($urandom());
            end
        endcase
    endfunction

    task automatic random_pixels(input int n);
        int          x0, y0, x1, y1, cov;
        logic [31:0] dest;
        clip_bounds(fb_cfg, x0, y0, x1, y1);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1:    cov = 0;
                2, 3:    cov = 255;
                4:       cov = 1;
                5:       cov = 254;
                default: cov = $urandom_range(255);
            endcase
            case ($urandom_range(9))
                0:       dest = 32'h0000_0000;
                1:       dest = 32'hFFFF_FFFF;
                default: dest = $urandom();
            endcase
            queue_pixel(pick_coord(x0, x1), pick_coord(y0, y1), cov, dest);
        end
    endtask

    task automatic random_setup();
        logic [31:0] color;
        color = $urandom();
        if ($urandom_range(9) < 4) begin
            color[31:24] = 8'hFF;
        end
        if ($urandom_range(3) == 0) begin
            set_clip(color, $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom());
        end else begin
            set_clip(color, $urandom_range(255) - 64, $urandom_range(255) - 64,
                     $urandom_range(240) - 40, $urandom_range(240) - 40,
                     $urandom_range(400), $urandom_range(400), $urandom_range(700));
        end
    endtask

    initial begin
        fb_cfg = '0;
        fb_cfg.fg_argb = gccb_pkg::FG_ARGB_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: the window collapses to the empty frame
        queue_pixel(0, 0, 255, 32'h1234_5678);
        queue_pixel(3, 7, 128, 32'hFFFF_FFFF);
        wait_idle();

        set_clip(32'h80FF_4020, -10, -5, 100, 50, 640, 480, 640);
        write_reg(REG_SPARE_LO, 32'h0000_0000);
        write_reg(REG_SPARE_HI, 32'h0000_0005);
        queue_pixel(-10, -5, 255, 32'hFFFF_FFFF);
        queue_pixel(89, 44, 128, 32'h0000_0000);
        queue_pixel(90, 0, 200, 32'hA5A5_5A5A);
        queue_pixel(0, 45, 200, 32'hA5A5_5A5A);
        queue_pixel(-11, 0, 200, 32'h0F0F_F0F0);
        queue_pixel(0, -6, 200, 32'h0F0F_F0F0);
        queue_pixel(5, 5, 0, 32'hDEAD_BEEF);
        queue_pixel(5, 5, 1, 32'hFFFF_FFFF);
        queue_pixel(5, 5, 255, 32'h1234_5678);
        queue_pixel(-32768, -32768, 255, 32'h0000_0000);
        queue_pixel(32767, 32767, 255, 32'hFFFF_FFFF);
        wait_idle();

        // right edge zero, bottom edge negative: frame size stands in
        set_clip(32'hFFFF_FFFF, 0, -100, 0, 50, 8191, 8191, 16383);
        queue_pixel(8190, 8190, 255, 32'h0000_0000);
        queue_pixel(8191, 0, 255, 32'h0000_0000);
        queue_pixel(0, 8191, 255, 32'h0000_0000);
        queue_pixel(0, -100, 254, 32'h8040_2010);
        queue_pixel(100, 100, 255, 32'h8040_2010);
        wait_idle();

        set_clip(32'h0000_0000, -32768, 32767, 32767, 32767, 0, 0, 0);
        queue_pixel(-32768, 32767, 255, 32'hFFFF_FFFF);
        queue_pixel(-1, 32767, 7, 32'h7F80_01FE);
        queue_pixel(0, 32767, 255, 32'hFFFF_FFFF);
        queue_pixel(-5, 32766, 255, 32'hFFFF_FFFF);
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            random_setup();
            @(posedge clk);
            steady <= (phase == 3);
            random_pixels(160);
            if (phase == 5) begin
                @(posedge clk);
                hold_requests <= hold_requests + 1;
            end
            wait_idle();
        end

        repeat (12) @(posedge clk);
        if (predicted_writes.size() != 0) begin
            report($sformatf("%0d results never arrived", predicted_writes.size()));
        end
        $display("%0d requests over 12 register setups, %0d framebuffer writes (%0d opaque)",
                 accepted, writes_seen, opaque_seen);
        $display("longest input back-pressure %0d cycles, %0d mismatches",
                 max_in_stall_run, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
